// ===== sv/kwm_pkg.sv =====
`default_nettype none

package kwm_pkg;

   localparam int DATA_W          = 32;
   localparam int STREAM_W        = 3;
   localparam int STATUS_W        = 2;
   localparam int REQ_TDATA_W     = 40;
   localparam int RSP_TDATA_W     = 40;
   localparam int NUM_STREAMS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 16;

   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_POP  = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // one queue operation per cycle; push and pop never fire together
   typedef struct packed {
      logic              push_en;
      logic              pop_en;
      logic [DATA_W-1:0] value;
   } bank_op_type;

endpackage

`default_nettype wire

// ===== sv/kwm_min_tree.sv =====
`default_nettype none

module kwm_min_tree #(
   parameter int  NUM_STREAMS = kwm_pkg::NUM_STREAMS_DEF,
   localparam int SEL_W       = $clog2(NUM_STREAMS)
) (
   input  logic [kwm_pkg::DATA_W-1:0] head_value [NUM_STREAMS],
   input  logic [NUM_STREAMS-1:0]     head_valid,
   output logic                       best_valid,
   output logic [kwm_pkg::DATA_W-1:0] best_value,
   output logic [SEL_W-1:0]           best_sel
);
   import kwm_pkg::*;

   localparam int LEAVES = 1 << SEL_W;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] value;
      logic [SEL_W-1:0]  sel;
   } node_type;

   // heap order: node i has children 2i+1 and 2i+2, leaves start at LEAVES-1
   node_type node [2*LEAVES-1];

   genvar j, i;
   generate
      for (j = 0; j < LEAVES; j++) begin : g_leaf
         if (j < NUM_STREAMS) begin : g_used
            assign node[LEAVES-1+j] = '{valid: head_valid[j], value: head_value[j],
                                        sel: SEL_W'(j)};
         end else begin : g_pad
            assign node[LEAVES-1+j] = '{valid: 1'b0, value: '0, sel: SEL_W'(j)};
         end
      end

      for (i = 0; i < LEAVES-1; i++) begin : g_node
         node_type lt;
         node_type rt;
         assign lt = node[2*i+1];
         assign rt = node[2*i+2];
         // left side holds the lower stream indexes, so it wins ties
         assign node[i] = (lt.valid && (!rt.valid || $signed(lt.value) <= $signed(rt.value)))
                          ? lt : rt;
      end
   endgenerate

   assign best_valid = node[0].valid;
   assign best_value = node[0].value;
   assign best_sel   = node[0].sel;

endmodule

`default_nettype wire

// ===== sv/kwm_bank.sv =====
`default_nettype none

module kwm_bank #(
   parameter int  NUM_STREAMS = kwm_pkg::NUM_STREAMS_DEF,
   parameter int  QUEUE_DEPTH = kwm_pkg::QUEUE_DEPTH_DEF,
   localparam int SEL_W       = $clog2(NUM_STREAMS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  kwm_pkg::bank_op_type        op,
   input  logic [SEL_W-1:0]            op_sel,
   output logic [kwm_pkg::DATA_W-1:0]  head_value [NUM_STREAMS],
   output logic [NUM_STREAMS-1:0]      head_valid,
   output logic [NUM_STREAMS-1:0]      full
);
   import kwm_pkg::*;

   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W    = SEL_W + PTR_W;
   localparam int MEM_WORDS = NUM_STREAMS << PTR_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [DATA_W-1:0] mem [MEM_WORDS];
   logic [DATA_W-1:0] mem_rd_ff;

   logic [PTR_W-1:0]  rd_ptr_ff [NUM_STREAMS];
   logic [PTR_W-1:0]  rd_ptr_in [NUM_STREAMS];
   logic [PTR_W-1:0]  wr_ptr_ff [NUM_STREAMS];
   logic [PTR_W-1:0]  wr_ptr_in [NUM_STREAMS];
   logic [CNT_W-1:0]  count_ff  [NUM_STREAMS];
   logic [CNT_W-1:0]  count_in  [NUM_STREAMS];
   logic [DATA_W-1:0] head_ff   [NUM_STREAMS];
   logic [DATA_W-1:0] head_in   [NUM_STREAMS];

   logic              fill_pend_ff;
   logic              fill_pend_in;
   logic [SEL_W-1:0]  fill_sel_ff;
   logic [SEL_W-1:0]  fill_sel_in;

   logic [PTR_W-1:0]  sel_rd_ptr;
   logic [PTR_W-1:0]  sel_rd_nxt;
   logic [PTR_W-1:0]  sel_wr_ptr;
   logic [PTR_W-1:0]  sel_wr_nxt;
   logic [CNT_W-1:0]  sel_count;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              refill;

   assign sel_rd_ptr = rd_ptr_ff[op_sel];
   assign sel_wr_ptr = wr_ptr_ff[op_sel];
   assign sel_count  = count_ff[op_sel];
   assign sel_rd_nxt = (sel_rd_ptr == PTR_LAST) ? '0 : sel_rd_ptr + 1'b1;
   assign sel_wr_nxt = (sel_wr_ptr == PTR_LAST) ? '0 : sel_wr_ptr + 1'b1;
   assign rd_addr    = {op_sel, sel_rd_nxt};
   assign wr_addr    = {op_sel, sel_wr_ptr};
   // a pop that leaves entries behind fetches the next head from the store
   assign refill     = op.pop_en && (sel_count > CNT_ONE);

   always_comb begin
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      fill_pend_in = refill;
      fill_sel_in  = op_sel;
      if (fill_pend_ff) begin
         head_in[fill_sel_ff] = mem_rd_ff;
      end
      if (op.push_en) begin
         wr_ptr_in[op_sel] = sel_wr_nxt;
         count_in[op_sel]  = sel_count + 1'b1;
         // an empty queue takes the value straight into its head
         if (sel_count == '0) begin
            head_in[op_sel] = op.value;
         end
      end
      if (op.pop_en) begin
         rd_ptr_in[op_sel] = sel_rd_nxt;
         count_in[op_sel]  = sel_count - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '{default: '0};
         wr_ptr_ff    <= '{default: '0};
         count_ff     <= '{default: '0};
         fill_pend_ff <= 1'b0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         fill_pend_ff <= fill_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      fill_sel_ff <= fill_sel_in;
   end

   always_ff @(posedge clock) begin
      if (op.push_en) begin
         mem[wr_addr] <= op.value;
      end
      if (refill) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   genvar s;
   generate
      for (s = 0; s < NUM_STREAMS; s++) begin : g_head
         // forward the fetched word while it is still on its way into the head register
         assign head_value[s] = (fill_pend_ff && fill_sel_ff == SEL_W'(s)) ? mem_rd_ff
                                                                           : head_ff[s];
         assign head_valid[s] = (count_ff[s] != '0);
         assign full[s]       = (count_ff[s] == CNT_FULL);
      end
   endgenerate

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      op.pop_en |-> head_valid[op_sel])
      else $error("pop issued to an empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      op.push_en |-> !full[op_sel])
      else $error("push issued to a full queue");

   a_refill_live: assert property (@(posedge clock) disable iff (reset)
      refill |=> fill_pend_ff && head_valid[fill_sel_ff])
      else $error("head fetch landed on an empty queue");

endmodule

`default_nettype wire

// ===== sv/k_way_sorted_merge.sv =====
// A req beat is taken into the input stage register; its result is loaded into the result
// register and offered on rsp once that register is free. One push or pop per cycle while
// rsp is not stalled; the head compare tree and the head fetch from the queue store both
// keep pace, with forwarding for the fetch. Each req beat gives exactly one rsp beat, in order.
// Reset (synchronous, active high) empties every queue and drops any beat in flight;
// the store itself is not cleared.
`default_nettype none

module k_way_sorted_merge #(
   parameter int NUM_STREAMS = kwm_pkg::NUM_STREAMS_DEF,
   parameter int QUEUE_DEPTH = kwm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kwm_pkg::REQ_TDATA_W-1:0] req_tdata,  // stream[2:0], value[34:3]
   input  logic                            req_tuser,  // kind[0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kwm_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // out_value[31:0], out_stream[34:32]
   output logic [kwm_pkg::STATUS_W-1:0]    rsp_tuser   // status[1:0]
);
   import kwm_pkg::*;

   localparam int SEL_W = $clog2(NUM_STREAMS);
   localparam int PAD_W = RSP_TDATA_W - DATA_W - STREAM_W;

   logic                in_valid_ff;
   logic                in_valid_in;
   kind_type            in_kind_ff;
   logic [STREAM_W-1:0] in_stream_ff;
   logic [DATA_W-1:0]   in_value_ff;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          rsp_status_ff;
   status_type          rsp_status_in;
   logic [DATA_W-1:0]   rsp_value_ff;
   logic [DATA_W-1:0]   rsp_value_in;
   logic [STREAM_W-1:0] rsp_stream_ff;
   logic [STREAM_W-1:0] rsp_stream_in;

   logic                req_fire;
   logic                advance;
   logic                is_push;
   logic                stream_ok;
   logic                push_ok;
   logic [SEL_W-1:0]    push_sel;
   logic [SEL_W-1:0]    op_sel;
   bank_op_type         op;

   logic [DATA_W-1:0]   head_value [NUM_STREAMS];
   logic [NUM_STREAMS-1:0] head_valid;
   logic [NUM_STREAMS-1:0] full;
   logic                best_valid;
   logic [DATA_W-1:0]   best_value;
   logic [SEL_W-1:0]    best_sel;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign is_push   = (in_kind_ff == KIND_PUSH);
   assign stream_ok = ({{(32-STREAM_W){1'b0}}, in_stream_ff} < 32'(NUM_STREAMS));
   assign push_sel  = SEL_W'(in_stream_ff);
   assign push_ok   = stream_ok && !full[push_sel];
   assign op_sel    = is_push ? push_sel : best_sel;

   assign op.push_en = advance && is_push && push_ok;
   assign op.pop_en  = advance && !is_push && best_valid;
   assign op.value   = in_value_ff;

   kwm_bank #(
      .NUM_STREAMS (NUM_STREAMS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_bank (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .op_sel     (op_sel),
      .head_value (head_value),
      .head_valid (head_valid),
      .full       (full)
   );

   kwm_min_tree #(
      .NUM_STREAMS (NUM_STREAMS)
   ) u_min_tree (
      .head_value (head_value),
      .head_valid (head_valid),
      .best_valid (best_valid),
      .best_value (best_value),
      .best_sel   (best_sel)
   );

   always_comb begin
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      rsp_stream_in = '0;
      case (in_kind_ff)
         KIND_PUSH: begin
            if (!push_ok) begin
               rsp_status_in = ST_FULL;
            end
         end
         KIND_POP: begin
            if (best_valid) begin
               rsp_value_in  = best_value;
               rsp_stream_in = STREAM_W'(best_sel);
            end else begin
               rsp_status_in = ST_EMPTY;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load on the beat that fills the stage, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff   <= kind_type'(req_tuser);
         in_stream_ff <= req_tdata[STREAM_W-1:0];
         in_value_ff  <= req_tdata[STREAM_W+DATA_W-1:STREAM_W];
      end
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_stream_ff <= rsp_stream_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_stream_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed beat did not reach the result register");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == '0 && rsp_stream_ff == '0)
      else $error("error result carries a value");

   a_pop_served: assert property (@(posedge clock) disable iff (reset)
      advance && !is_push && best_valid |=> rsp_status_ff == ST_OK)
      else $error("pop with a live head reported an error");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_value_ff))
      else $error("stalled input stage lost its beat");

endmodule

`default_nettype wire

// ===== tb/k_way_sorted_merge_tb.sv =====
`timescale 1ns / 1ps

module k_way_sorted_merge_tb;
   import kwm_pkg::*;

   localparam int NS          = NUM_STREAMS_DEF;
   localparam int QD          = QUEUE_DEPTH_DEF;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 300;

   typedef struct packed {
      kind_type          kind;
      logic [2:0]        stream;
      logic [DATA_W-1:0] value;
   } merge_op_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] value;
      logic [2:0]        stream;
   } merge_result_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // stream[2:0], value[34:3]
   logic                   req_tuser  = 1'b0; // kind[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // out_value[31:0], out_stream[34:32]
   logic [STATUS_W-1:0]    rsp_tuser;        // status[1:0]

   // per-stream FIFO mirror
   logic [DATA_W-1:0] lane_mem [NS][QD];
   int                lane_rd    [NS];
   int                lane_count [NS];
   logic [DATA_W-1:0] lane_ramp  [NS];

   merge_op_type     pending_ops [$];
   merge_result_type merge_results [$];

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   error_count    = 0;
   int   gen_count      = 0;
   logic rsp_hold       = 1'b0;
   logic hold_go        = 1'b0;
   logic hold_done      = 1'b0;

   k_way_sorted_merge u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic merge_result_type apply_merge_op(input kind_type kind,
                                                       input logic [2:0] stream,
                                                       input logic [DATA_W-1:0] value);
      merge_result_type res;
      bit               found;
      int               best;
      logic [DATA_W-1:0] head;
      res   = '{status: ST_OK, value: '0, stream: '0};
      found = 0;
      best  = 0;
      if (kind == KIND_PUSH) begin
         if (int'(stream) >= NS || lane_count[stream] >= QD) begin
            res.status = ST_FULL;
         end else begin
            lane_mem[stream][(lane_rd[stream] + lane_count[stream]) % QD] = value;
            lane_count[stream]++;
         end
      end else begin
         // strict compare keeps the lowest stream on equal heads
         for (int s = 0; s < NS; s++) begin
            if (lane_count[s] != 0) begin
               head = lane_mem[s][lane_rd[s]];
               if (!found || $signed(head) < $signed(res.value)) begin
                  found     = 1;
                  best      = s;
                  res.value = head;
               end
            end
         end
         if (!found) begin
            res.status = ST_EMPTY;
         end else begin
            res.stream       = 3'(best);
            lane_rd[best]    = (lane_rd[best] + 1) % QD;
            lane_count[best] = lane_count[best] - 1;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   function automatic logic [DATA_W-1:0] pick_value(input int mode, input int s);
      case (mode)
         0: return $urandom;
         1: return 32'(int'($urandom_range(8)) - 4);
         2: begin
            case ($urandom_range(4))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               3:       return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         default: begin
            // ascending run per stream, small steps to make ties common
            lane_ramp[s] = lane_ramp[s] + $urandom_range(3);
            return lane_ramp[s];
         end
      endcase
   endfunction

   task automatic queue_op(input kind_type kind, input logic [2:0] stream,
                           input logic [DATA_W-1:0] value);
      pending_ops.push_back('{kind: kind, stream: stream, value: value});
      gen_count++;
   endtask

   task automatic add_burst();
      int style;
      int vmode;
      int s;
      int pct;
      style = $urandom_range(9);
      vmode = $urandom_range(3);
      s     = $urandom_range(NS - 1);
      case (style)
         0: repeat (QD + 1 + $urandom_range(2))
               queue_op(KIND_PUSH, 3'(s), pick_value(vmode, s));
         1: repeat (5 + $urandom_range(35))
               queue_op(KIND_POP, 3'($urandom), $urandom);
         8, 9: repeat (8 + $urandom_range(16))
               queue_op(kind_type'($urandom_range(1)), 3'($urandom), $urandom);
         default: begin
            pct = $urandom_range(80, 20);
            repeat (8 + $urandom_range(24)) begin
               if ($urandom_range(99) < pct) begin
                  s = $urandom_range(NS - 1);
                  queue_op(KIND_PUSH, 3'(s), pick_value(vmode, s));
               end else begin
                  queue_op(KIND_POP, 3'($urandom), $urandom);
               end
            end
         end
      endcase
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_ops.size() != 0 || merge_results.size() != 0 || req_tvalid)
         @(negedge clock);
   endtask

   // sender: advance to the next beat once the current one is taken
   always @(posedge clock) begin : req_driver
      merge_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            merge_results.push_back(apply_merge_op(kind_type'(req_tuser),
                                                   req_tdata[2:0], req_tdata[34:3]));
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {5'b0, op.value, op.stream};
               req_tuser  <= op.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_sink
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off so the block backs up into its input
   initial begin : rsp_holdoff
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold  <= 1'b0;
      hold_done <= 1'b1;
   end

   always @(posedge clock) begin : rsp_monitor
      merge_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (merge_results.size() == 0) begin
            report_mismatch("result beat with nothing outstanding");
         end else begin
            want = merge_results.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[31:0] !== want.value ||
                rsp_tdata[34:32] !== want.stream)
               report_mismatch($sformatf(
                  "status %0d/%0d value %h/%h stream %0d/%0d (got/want)",
                  rsp_tuser, want.status, rsp_tdata[31:0], want.value,
                  rsp_tdata[34:32], want.stream));
         end
      end
   end

   initial begin : stimulus
      int idle_plan  [4];
      int stall_plan [4];
      int s;
      idle_plan  = '{0, 49, 0, 17};
      stall_plan = '{0, 0, 49, 17};
      for (int i = 0; i < NS; i++) begin
         lane_rd[i]    = 0;
         lane_count[i] = 0;
         lane_ramp[i]  = 32'(int'($urandom_range(64)) - 32);
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, extremes, tie on equal heads, drain back to empty
      queue_op(KIND_POP,  3'd0, 32'h0);
      queue_op(KIND_PUSH, 3'd0, 32'h8000_0000);
      queue_op(KIND_PUSH, 3'd7, 32'h7FFF_FFFF);
      queue_op(KIND_PUSH, 3'd3, 32'h0000_0000);
      queue_op(KIND_PUSH, 3'd5, 32'hFFFF_FFFF);
      queue_op(KIND_PUSH, 3'd2, 32'h0000_0000);
      repeat (6) queue_op(KIND_POP, 3'd7, 32'hFFFF_FFFF);
      wait_idle();

      gen_count = 0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_plan[ph];
         recv_stall_pct = stall_plan[ph];
         if (ph == 0) begin
            // overflow one stream, then pull it back out
            s = $urandom_range(NS - 1);
            repeat (QD + 2) queue_op(KIND_PUSH, 3'(s), $urandom);
            repeat (QD + 4) queue_op(KIND_POP, 3'($urandom), $urandom);
         end
         while (gen_count < PHASE_ITEMS * (ph + 1))
            add_burst();
         wait_idle();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_go        = 1'b1;
      repeat (60) begin
         s = $urandom_range(NS - 1);
         queue_op(KIND_PUSH, 3'(s), pick_value($urandom_range(3), s));
      end
      repeat (20) queue_op(KIND_POP, 3'($urandom), $urandom);
      wait (hold_done);
      wait_idle();

      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
sv/kwm_pkg.sv
sv/kwm_min_tree.sv
sv/kwm_bank.sv
sv/k_way_sorted_merge.sv
tb/k_way_sorted_merge_tb.sv
